### hdl/rpn_pkg.sv
`timescale 1ns / 1ps
package rpn_pkg;

  // Token codes
  typedef enum logic [3:0] {
    ACT_PUSH = 4'd0,
    ACT_ADD  = 4'd1,
    ACT_SUB  = 4'd2,
    ACT_MUL  = 4'd3,
    ACT_DIV  = 4'd4,
    ACT_MAX  = 4'd5,
    ACT_MIN  = 4'd6,
    ACT_POW  = 4'd7,
    ACT_ABS  = 4'd8
  } action_e;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_EXEC,
    S_START,
    S_ITER,
    S_WB,
    S_TOP,
    S_FIN,
    S_OUT
  } state_e;

  localparam int unsigned DataW = 32;
  localparam int unsigned IterW = 6;

  // Controller to datapath commands
  typedef struct packed {
    logic    capture;   // latch incoming token
    logic    rd_b;      // issue read of top entry
    logic    rd_a;      // issue read of second entry
    logic    lat_b;     // latch read data as right operand
    logic    lat_a;     // latch read data as left operand
    logic    start;     // begin execution of the operation
    logic    iter;      // one division / power step
    logic    push;      // write token value at count
    logic    wb;        // write result, pop one if binary
    logic    rd_top;    // read top for result
    logic    finish;    // form result, clear count and status
    logic    err;       // record error
    status_e err_code;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    action_e act;
    logic    last;
    logic    cnt_zero;
    logic    cnt_lt2;
    logic    full;
    logic    op_err;    // divide by zero, or zero to a negative power, for the latched operands
    logic    needs_iter;
    logic    iter_done;
  } stat_t;

endpackage

### hdl/rpn_ram.sv
`timescale 1ns / 1ps
module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Single write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/rpn_datapath.sv
`timescale 1ns / 1ps
module rpn_datapath
  import rpn_pkg::*;
#(
  parameter int unsigned StackDepth = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [3:0]   action_i,
  input  logic [31:0]  operand_value_i,
  input  logic         end_of_expression_i,
  input  cmd_t         cmd_i,
  output stat_t        stat_o,
  output logic [31:0]  result_value_o,
  output logic [1:0]   status_o
);

  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned CntW  = $clog2(StackDepth + 1);

  logic [3:0]       act_q;
  logic [31:0]      val_q;
  logic             last_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  status_e          sticky_q, sticky_d;
  logic [31:0]      a_q, b_q, res_q, res_d;
  logic [31:0]      rem_q, rem_d, quo_q, quo_d, base_q, base_d, expo_q, expo_d;
  logic [IterW-1:0] it_q, it_d;
  logic             neg_q, neg_d;
  logic [31:0]      result_q;
  logic [1:0]       status_q;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]      wdata, rdata;

  // Stack storage
  rpn_ram #(.Width(DataW), .Depth(StackDepth)) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [CntW-1:0] cnt_m1, cnt_m2;
  assign cnt_m1 = cnt_q - CntW'(1);
  assign cnt_m2 = cnt_q - CntW'(2);

  // Read address
  always_comb begin
    raddr = cnt_m1[AddrW-1:0];
    if (cmd_i.rd_a) raddr = cnt_m2[AddrW-1:0];
  end

  // Write port
  always_comb begin
    we    = cmd_i.push | cmd_i.wb;
    waddr = cnt_q[AddrW-1:0];
    wdata = val_q;
    if (cmd_i.wb) begin
      waddr = (act_q == ACT_ABS) ? cnt_m1[AddrW-1:0] : cnt_m2[AddrW-1:0];
      wdata = res_q;
    end
  end

  logic [31:0] mag_a, mag_b, prod, sq, diff;
  logic [32:0] trial;
  logic        a_lt_b;
  assign mag_a  = a_q[31] ? (32'd0 - a_q) : a_q;
  assign mag_b  = b_q[31] ? (32'd0 - b_q) : b_q;
  assign a_lt_b = $signed(a_q) < $signed(b_q);
  assign prod   = a_q * b_q;
  assign diff   = a_q - b_q;
  assign sq     = base_q * base_q;
  assign trial  = {rem_q[30:0], quo_q[31]} - {1'b0, mag_b};

  // Operation and iterative units
  always_comb begin
    res_d  = res_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    base_d = base_q;
    expo_d = expo_q;
    it_d   = it_q;
    neg_d  = neg_q;
    if (cmd_i.start) begin
      it_d = '0;
      case (act_q)
        ACT_ADD: res_d = a_q + b_q;
        ACT_SUB: res_d = diff;
        ACT_MUL: res_d = prod;
        ACT_MAX: res_d = a_lt_b ? b_q : a_q;
        ACT_MIN: res_d = a_lt_b ? a_q : b_q;
        ACT_ABS: res_d = mag_b;
        ACT_DIV: begin
          rem_d = '0;
          quo_d = mag_a;
          neg_d = a_q[31] ^ b_q[31];
        end
        ACT_POW: begin
          base_d = a_q;
          expo_d = b_q;
          res_d  = 32'd1;
          if (b_q[31]) begin
            if (a_q == 32'd1) res_d = 32'd1;
            else if (a_q == 32'hFFFF_FFFF) res_d = b_q[0] ? 32'hFFFF_FFFF : 32'd1;
            else res_d = '0;
            expo_d = '0;
          end
        end
        default: res_d = res_q;
      endcase
    end else if (cmd_i.iter) begin
      it_d = it_q + IterW'(1);
      if (act_q == ACT_DIV) begin
        // restoring division, one quotient bit per step
        if (!trial[32]) begin
          rem_d = trial[31:0];
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = {rem_q[30:0], quo_q[31]};
          quo_d = {quo_q[30:0], 1'b0};
        end
        if (it_q == IterW'(31)) begin
          res_d = neg_q ? (32'd0 - quo_d) : quo_d;
        end
      end else begin
        // square and multiply, one exponent bit per step
        if (expo_q[0]) res_d = res_q * base_q;
        base_d = sq;
        expo_d = {1'b0, expo_q[31:1]};
      end
    end
  end

  // Stack count and sticky status
  always_comb begin
    cnt_d    = cnt_q;
    sticky_d = sticky_q;
    if (cmd_i.push) cnt_d = cnt_q + CntW'(1);
    if (cmd_i.wb && act_q != ACT_ABS) cnt_d = cnt_m1;
    if (cmd_i.err && sticky_q == ST_OK) sticky_d = cmd_i.err_code;
    if (cmd_i.finish) begin
      cnt_d    = '0;
      sticky_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sticky_q <= ST_OK;
    end else begin
      cnt_q    <= cnt_d;
      sticky_q <= sticky_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      val_q  <= operand_value_i;
      last_q <= end_of_expression_i;
    end
    if (cmd_i.lat_b) b_q <= rdata;
    if (cmd_i.lat_a) a_q <= rdata;
    res_q  <= res_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    base_q <= base_d;
    expo_q <= expo_d;
    it_q   <= it_d;
    neg_q  <= neg_d;
    if (cmd_i.finish) begin
      // an empty stack reports underflow unless an earlier error stands
      result_q <= (cnt_q == '0) ? 32'd0 : rdata;
      status_q <= (sticky_q == ST_OK && cnt_q == '0) ? ST_UNDERFLOW : sticky_q;
    end
  end

  assign result_value_o = result_q;
  assign status_o       = status_q;

  // Status towards the controller
  always_comb begin
    stat_o.act        = action_e'(act_q);
    stat_o.last       = last_q;
    stat_o.cnt_zero   = (cnt_q == '0);
    stat_o.cnt_lt2    = (cnt_q < CntW'(2));
    stat_o.full       = (cnt_q >= CntW'(StackDepth));
    stat_o.op_err     = (act_q == ACT_DIV && b_q == '0) ||
                        (act_q == ACT_POW && b_q[31] && a_q == '0);
    stat_o.needs_iter = (act_q == ACT_DIV) || (act_q == ACT_POW);
    stat_o.iter_done  = (act_q == ACT_DIV) ? (it_q == IterW'(32)) : (expo_q == '0);
  end

endmodule

### hdl/rpn_ctrl.sv
`timescale 1ns / 1ps
module rpn_ctrl
  import rpn_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   is_bin;
  assign is_bin = stat_i.act >= ACT_ADD && stat_i.act <= ACT_POW;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RD1;
      S_RD1: begin
        // decode: errors and push finish here
        if (stat_i.act == ACT_PUSH) state_d = S_TOP;
        else if (is_bin && !stat_i.cnt_lt2) state_d = S_RD2;
        else if (stat_i.act == ACT_ABS && !stat_i.cnt_zero) state_d = S_EXEC;
        else state_d = S_TOP;
      end
      S_RD2:  state_d = S_EXEC;
      S_EXEC: state_d = S_START;
      S_START: begin
        if (stat_i.op_err) state_d = S_TOP;
        else if (stat_i.needs_iter) state_d = S_ITER;
        else state_d = S_WB;
      end
      S_ITER: if (stat_i.iter_done) state_d = S_WB;
      S_WB:   state_d = S_TOP;
      S_TOP:  state_d = stat_i.last ? S_FIN : S_IDLE;
      S_FIN:  state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.err_code = ST_OK;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_RD1: begin
        cmd_o.rd_b = 1'b1;
        if (stat_i.act == ACT_PUSH) begin
          if (stat_i.full) begin
            cmd_o.err = 1'b1;
            cmd_o.err_code = ST_OVERFLOW;
          end else begin
            cmd_o.push = 1'b1;
          end
        end else if ((is_bin && stat_i.cnt_lt2) ||
                     (stat_i.act == ACT_ABS && stat_i.cnt_zero)) begin
          cmd_o.err = 1'b1;
          cmd_o.err_code = ST_UNDERFLOW;
        end
      end
      S_RD2: begin
        cmd_o.rd_a  = 1'b1;
        cmd_o.lat_b = 1'b1;
      end
      S_EXEC: begin
        if (stat_i.act == ACT_ABS) begin
          cmd_o.lat_b = 1'b1;
        end else begin
          cmd_o.lat_a = 1'b1;
        end
      end
      // operands are latched now: reject or start
      S_START: begin
        if (stat_i.op_err) begin
          cmd_o.err = 1'b1;
          cmd_o.err_code = ST_DIVZERO;
        end else begin
          cmd_o.start = 1'b1;
        end
      end
      S_ITER: cmd_o.iter = !stat_i.iter_done;
      S_WB:   cmd_o.wb = 1'b1;
      S_TOP:  cmd_o.rd_top = 1'b1;
      S_FIN:  cmd_o.finish = 1'b1;
      S_OUT:  out_valid_o = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

### hdl/rpn_stack_evaluator_top.sv
`timescale 1ns / 1ps
// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    action_i, operand_value_i, end_of_expression_i
// out      out_valid_o / out_ready_i  result_value_o, status_o
//
// Path of a token: push, unused code, underflow and overflow go from decode to the top
// read; abs and binary operations latch their operands, start and write back, divide
// (one quotient bit per cycle) and power (per bit of a non-negative exponent) iterating;
// divide by zero skips the write back. A last token then loads the result and waits
// for out_ready_i. Reset clears the stack count and status; stack entries need no clearing.
// One token is in flight at a time; the iterative divide / power unit sets the worst case.
module rpn_stack_evaluator_top
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  action_i,
  input  logic [31:0] operand_value_i,
  input  logic        end_of_expression_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_value_o,
  output logic [1:0]  status_o
);

  cmd_t  cmd;
  stat_t stat;

  rpn_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  rpn_datapath #(.StackDepth(STACK_DEPTH)) u_dp (
    .clk_i, .rst_ni, .action_i, .operand_value_i, .end_of_expression_i,
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while result pending");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(result_value_o) && $stable(status_o))
    else $error("result changed while waiting for transfer");

endmodule

### sim/rpn_stack_evaluator_top_test.sv
`timescale 1ns / 1ps
module rpn_stack_evaluator_top_test;
  import rpn_pkg::*;

  localparam int unsigned Depth = 16;
  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  action_i = '0;
  logic [31:0] operand_value_i = '0;
  logic        end_of_expression_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] result_value_o;
  logic [1:0]  status_o;

  rpn_stack_evaluator_top #(.STACK_DEPTH(Depth)) DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .operand_value_i,
    .end_of_expression_i, .out_valid_o, .out_ready_i, .result_value_o, .status_o
  );

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [31:0] value;
    status_e     st;
  } answer_t;

  typedef struct {
    logic [3:0]  act;
    logic [31:0] val;
    logic        last;
    logic        typed;  // answer is written in the row
    answer_t     ans;
  } token_row_t;

  // Predictor state
  logic [31:0] calc_stack[Depth];
  int unsigned calc_count;
  status_e     calc_status;

  answer_t     answer_q[$];
  answer_t     typed_q[$];  // typed answers, zero when none
  logic        typed_has_q[$];
  int unsigned mismatches;
  int unsigned cycles;

  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [31:0] raise_wrap(logic [31:0] b, logic [31:0] e);
    logic [31:0] acc;
    acc = 32'd1;
    while (e != 0) begin
      if (e[0]) acc = acc * b;
      b = b * b;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic void note_fault(status_e code);
    if (calc_status == ST_OK) calc_status = code;
  endfunction

  // Applies one token to the predictor; returns 1 with an answer on a last token
  function automatic bit eval_token(logic [3:0] act, logic [31:0] val, logic last,
                                    output answer_t ans);
    logic [31:0] a, b, r;
    status_e code;
    code = ST_OK;
    r = '0;
    ans = '0;
    if (act == ACT_PUSH) begin
      if (calc_count >= Depth) note_fault(ST_OVERFLOW);
      else begin
        calc_stack[calc_count] = val;
        calc_count++;
      end
    end else if (act >= ACT_ADD && act <= ACT_POW) begin
      if (calc_count < 2) note_fault(ST_UNDERFLOW);
      else begin
        a = calc_stack[calc_count-2];
        b = calc_stack[calc_count-1];
        case (act)
          ACT_ADD: r = a + b;
          ACT_SUB: r = a - b;
          ACT_MUL: r = a * b;
          ACT_DIV: begin
            if (b == 0) code = ST_DIVZERO;
            else begin
              r = mag32(a) / mag32(b);
              if (a[31] != b[31]) r = -r;
            end
          end
          ACT_MAX: r = ($signed(a) < $signed(b)) ? b : a;
          ACT_MIN: r = ($signed(b) < $signed(a)) ? b : a;
          default: begin
            if (b[31]) begin
              if (a == 0) code = ST_DIVZERO;
              else if (a == 32'd1) r = 32'd1;
              else if (a == 32'hFFFF_FFFF) r = b[0] ? 32'hFFFF_FFFF : 32'd1;
              else r = '0;
            end else r = raise_wrap(a, b);
          end
        endcase
        if (code != ST_OK) note_fault(code);
        else begin
          calc_count--;
          calc_stack[calc_count-1] = r;
        end
      end
    end else if (act == ACT_ABS) begin
      if (calc_count < 1) note_fault(ST_UNDERFLOW);
      else calc_stack[calc_count-1] = mag32(calc_stack[calc_count-1]);
    end
    if (!last) return 0;
    if (calc_count == 0) note_fault(ST_UNDERFLOW);
    else ans.value = calc_stack[calc_count-1];
    ans.st = calc_status;
    calc_count = 0;
    calc_status = ST_OK;
    return 1;
  endfunction

  // Drive one token and wait for its transfer
  task automatic send_token(logic [3:0] act, logic [31:0] val, logic last,
                            bit typed, answer_t typed_ans);
    answer_t ans;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) in_valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
    in_valid_i <= 1'b1;
    action_i <= act;
    operand_value_i <= val;
    end_of_expression_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (eval_token(act, val, last, ans)) begin
      answer_q.push_back(ans);
      typed_has_q.push_back(typed);
      typed_q.push_back(typed_ans);
    end
  endtask

  // Output side: random stalls, compare each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        answer_t want;
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result value=%h status=%0d", result_value_o, status_o);
        end else begin
          want = answer_q.pop_front();
          if (typed_has_q.pop_front()) begin
            answer_t t;
            t = typed_q.pop_front();
            if (t != want) begin
              mismatches++;
              if (mismatches <= 10)
                $display("table row disagrees: row %h/%0d predictor %h/%0d",
                         t.value, t.st, want.value, want.st);
            end
          end else void'(typed_q.pop_front());
          if (result_value_o !== want.value || status_o !== want.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                       want.value, want.st, result_value_o, status_o);
          end
        end
      end
      if ($urandom_range(0, 19) == 0) out_ready_i <= 1'b0;
      else if ($urandom_range(0, 3) != 0) out_ready_i <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  token_row_t table_rows[$];

  function automatic void add_row(logic [3:0] act, logic [31:0] val, logic last,
                                  bit typed = 0, logic [31:0] v = 0,
                                  status_e st = ST_OK);
    token_row_t row;
    row.act = act; row.val = val; row.last = last; row.typed = typed;
    row.ans.value = v; row.ans.st = st;
    table_rows.push_back(row);
  endfunction

  // Random well-formed-ish expression
  task automatic random_expression(ref int sent);
    int depth, n;
    logic [31:0] v;
    logic [3:0] act;
    depth = 0;
    n = $urandom_range(1, 12);
    if ($urandom_range(0, 30) == 0) n = 20;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom_range(0, 7) - 3;
        2: v = {1'($urandom_range(0, 1)), {31{1'($urandom_range(0, 1))}}};
        default: v = $urandom_range(0, 40);
      endcase
      if ($urandom_range(0, 9) == 0) act = 4'($urandom_range(0, 15));
      else if (depth < 2 || $urandom_range(0, 2) == 0) act = ACT_PUSH;
      else act = 4'($urandom_range(ACT_ADD, ACT_ABS));
      if (act == ACT_PUSH) depth++;
      else if (act >= ACT_ADD && act <= ACT_POW && depth >= 2) depth--;
      send_token(act, v, (i == n - 1), 0, '0);
      sent++;
    end
  endtask

  initial begin
    int sent;
    cycles = 0;
    mismatches = 0;
    calc_count = 0;
    calc_status = ST_OK;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    add_row(ACT_ADD, 0, 1, 1, 0, ST_UNDERFLOW);            // empty stack at the end
    add_row(ACT_PUSH, 32'h7FFF_FFFF, 0);
    add_row(ACT_PUSH, 32'd1, 0);
    add_row(ACT_ADD, 0, 1, 1, 32'h8000_0000, ST_OK);       // wrap on add
    add_row(ACT_PUSH, 32'h8000_0000, 0);
    add_row(ACT_ABS, 0, 1, 1, 32'h8000_0000, ST_OK);       // most negative abs
    add_row(ACT_PUSH, 32'h8000_0000, 0);
    add_row(ACT_PUSH, 32'hFFFF_FFFF, 0);
    add_row(ACT_DIV, 0, 1, 1, 32'h8000_0000, ST_OK);       // most negative / -1
    add_row(ACT_PUSH, 32'd5, 0);
    add_row(ACT_PUSH, 32'd0, 0);
    add_row(ACT_DIV, 0, 1, 1, 32'd0, ST_DIVZERO);          // stack left as it was
    add_row(ACT_PUSH, 32'd0, 0);
    add_row(ACT_PUSH, 32'hFFFF_FFFF, 0);
    add_row(ACT_POW, 0, 1, 1, 32'hFFFF_FFFF, ST_DIVZERO);  // zero to a negative power
    add_row(ACT_PUSH, 32'hFFFF_FFFF, 0);
    add_row(ACT_PUSH, 32'hFFFF_FFFD, 0);
    add_row(ACT_POW, 0, 0);
    add_row(ACT_PUSH, 32'hFFFF_FFF9, 0);
    add_row(ACT_PUSH, 32'd0, 0);
    add_row(ACT_POW, 0, 0);
    add_row(ACT_SUB, 0, 0);
    add_row(4'd15, 32'hFFFF_FFFF, 0);                       // unused code
    add_row(ACT_PUSH, 32'd3, 0);
    add_row(ACT_PUSH, -32'sd7, 0);
    foreach (table_rows[i])
      send_token(table_rows[i].act, table_rows[i].val, table_rows[i].last,
                 table_rows[i].typed, table_rows[i].ans);
    send_token(ACT_MUL, 0, 0, 0, '0);
    send_token(ACT_PUSH, 32'd2, 0, 0, '0);
    send_token(ACT_MAX, 0, 0, 0, '0);
    send_token(ACT_PUSH, 32'd9, 0, 0, '0);
    send_token(ACT_MIN, 0, 1, 0, '0);
    // Overflow: fill past depth
    for (int i = 0; i <= Depth; i++) send_token(ACT_PUSH, i, 0, 0, '0);
    send_token(ACT_ADD, 0, 1, 0, '0);

    sent = 0;
    while (sent < 800) random_expression(sent);
    in_valid_i <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
